// ===== hdl/lcabl_pkg.sv =====
// Shared types and constants of the binary-lifting lowest common ancestor block.
// Used by lca_binary_lifting and its testbench; depends on nothing else.
package lcabl_pkg;

  // Fixed field widths of the stream beats.
  localparam int unsigned NODE_W     = 10;
  localparam int unsigned KIND_W     = 1;
  localparam int unsigned DEPTH_BITS = 10;
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

  // Beat widths: two node numbers rounded up to whole bytes on the input,
  // one node number rounded up to whole bytes on the output.
  localparam int unsigned S_TDATA_W = ((2 * NODE_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((NODE_W + 7) / 8) * 8;

  // Defaults of the top-level parameters.
  localparam int unsigned MAX_NODES_DEF = 1024;
  localparam int unsigned LEVELS_DEF    = 10;

  // Item kinds carried in tuser.
  localparam logic [KIND_W-1:0] KIND_ATTACH = 1'b0;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_AT_DRD,
    ST_AT_DWR,
    ST_AT_RD,
    ST_AT_WR,
    ST_Q_DA,
    ST_Q_DB,
    ST_Q_SWAP,
    ST_Q_LIFT,
    ST_Q_LWAIT,
    ST_Q_CHK,
    ST_Q_UA,
    ST_Q_UB,
    ST_Q_CMP,
    ST_Q_FIN
  } lcabl_state_e;

endpackage

// ===== hdl/lca_binary_lifting.sv =====
// Lowest common ancestor by binary lifting over a stored ancestor table.
// One beat is in work at a time, and every table step costs a RAM read turnaround.
// After reset a clearing pass zeroes both stores before the first input beat is taken.
// A finished result waits in an output register, and the next input beat is taken
// while it waits.
// Depends on lcabl_pkg and lcabl_ram.
module lca_binary_lifting #(
  parameter int unsigned MAX_NODES = lcabl_pkg::MAX_NODES_DEF,
  parameter int unsigned LEVELS    = lcabl_pkg::LEVELS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream.
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // tdata fields from bit 0 up: node_a[9:0], node_b[19:10], zero fill.
  input  logic [lcabl_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // tuser fields from bit 0 up: kind (0 attach, 1 query).
  input  logic [lcabl_pkg::KIND_W-1:0]    s_axis_tuser_i,
  // Result stream.
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // tdata fields from bit 0 up: ancestor[9:0], zero fill.
  output logic [lcabl_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);

  import lcabl_pkg::*;

  // The ancestor table holds LEVELS entries per node, row by row: entry j of node n
  // sits at n*LEVELS + j and names the 2^j-th ancestor of n.
  localparam int unsigned TBL_DEPTH = MAX_NODES * LEVELS;
  localparam int unsigned TAW       = $clog2(TBL_DEPTH);
  localparam int unsigned DAW       = $clog2(MAX_NODES);
  localparam int unsigned JMAX      = (LEVELS > DEPTH_BITS) ? LEVELS : DEPTH_BITS;
  localparam int unsigned JW        = $clog2(JMAX + 1);

  lcabl_state_e state_q, state_d;

  logic [TAW-1:0]        clr_q, clr_d;
  logic [NODE_W-1:0]     a_q, a_d;
  logic [NODE_W-1:0]     b_q, b_d;
  logic [NODE_W-1:0]     ua_q, ua_d;
  logic [DEPTH_BITS-1:0] da_q, da_d;
  logic [DEPTH_BITS-1:0] k_q, k_d;
  logic [JW-1:0]         j_q, j_d;
  logic                  out_valid_q, out_valid_d;
  logic [NODE_W-1:0]     out_data_q, out_data_d;

  // Memory ports.
  logic                  tbl_we;
  logic [TAW-1:0]        tbl_waddr, tbl_raddr;
  logic [NODE_W-1:0]     tbl_wdata, tbl_rdata;
  logic                  dep_we;
  logic [DAW-1:0]        dep_waddr, dep_raddr;
  logic [DEPTH_BITS-1:0] dep_wdata, dep_rdata;

  logic                  in_fire;
  logic [KIND_W-1:0]     in_kind;
  logic [NODE_W-1:0]     in_node_a, in_node_b;
  logic                  attach_ok;
  logic                  slot_free;
  logic                  lift_in_table;
  logic [DEPTH_BITS-1:0] depth_inc;

  // Node numbers at or above MAX_NODES stand for the sentinel.
  function automatic logic [NODE_W-1:0] node_of(input logic [NODE_W-1:0] n);
    return (32'(n) < MAX_NODES) ? n : '0;
  endfunction

  function automatic logic [TAW-1:0] tbl_addr(input logic [NODE_W-1:0] n,
                                              input logic [JW-1:0]     lev);
    return TAW'(n) * TAW'(LEVELS) + TAW'(lev);
  endfunction

  assign in_kind   = s_axis_tuser_i;
  assign in_node_a = s_axis_tdata_i[NODE_W-1:0];
  assign in_node_b = s_axis_tdata_i[2*NODE_W-1:NODE_W];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // An attach of the sentinel, or of a node out of range, leaves everything as is.
  assign attach_ok = (in_node_a != '0) && (32'(in_node_a) < MAX_NODES);

  // The result register can be loaded when empty or when it drains this cycle.
  assign slot_free = !out_valid_q || m_axis_tready_i;

  assign lift_in_table = 32'(j_q) < LEVELS;

  // Parent depth plus one, saturating at the largest depth.
  assign depth_inc = (dep_rdata == DEPTH_MAX) ? DEPTH_MAX : dep_rdata + 1'b1;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == TAW'(TBL_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_kind == KIND_QUERY) begin
            state_d = ST_Q_DA;
          end else if (attach_ok) begin
            state_d = ST_AT_DRD;
          end
        end
      end
      ST_AT_DRD: state_d = ST_AT_DWR;
      ST_AT_DWR: state_d = (LEVELS == 1) ? ST_IDLE : ST_AT_RD;
      ST_AT_RD:  state_d = ST_AT_WR;
      ST_AT_WR: begin
        if (j_q == JW'(LEVELS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_AT_RD;
        end
      end
      ST_Q_DA:   state_d = ST_Q_DB;
      ST_Q_DB:   state_d = ST_Q_SWAP;
      ST_Q_SWAP: state_d = ST_Q_LIFT;
      ST_Q_LIFT: begin
        if (k_q == '0) begin
          state_d = ST_Q_CHK;
        end else if (k_q[0] && lift_in_table) begin
          state_d = ST_Q_LWAIT;
        end
      end
      ST_Q_LWAIT: state_d = ST_Q_LIFT;
      ST_Q_CHK: begin
        if (a_q != b_q) begin
          state_d = ST_Q_UA;
        end else if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_Q_UA: state_d = ST_Q_UB;
      ST_Q_UB: state_d = ST_Q_CMP;
      ST_Q_CMP: begin
        state_d = (j_q == '0) ? ST_Q_FIN : ST_Q_UA;
      end
      ST_Q_FIN: begin
        // The parent read issued in the last compare step stays on the port while
        // the result waits.
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    clr_d       = clr_q;
    a_d         = a_q;
    b_d         = b_q;
    ua_d        = ua_q;
    da_d        = da_q;
    k_d         = k_q;
    j_d         = j_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    tbl_we      = 1'b0;
    tbl_waddr   = tbl_addr(a_q, j_q);
    tbl_wdata   = tbl_rdata;
    tbl_raddr   = tbl_addr(a_q, j_q);
    dep_we      = 1'b0;
    dep_waddr   = DAW'(a_q);
    dep_wdata   = depth_inc;
    dep_raddr   = DAW'(a_q);
    case (state_q)
      ST_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_q;
        tbl_wdata = '0;
        dep_we    = 32'(clr_q) < MAX_NODES;
        dep_waddr = DAW'(clr_q);
        dep_wdata = '0;
        clr_d     = clr_q + 1'b1;
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_kind == KIND_QUERY) begin
            a_d = node_of(in_node_a);
          end else begin
            a_d = in_node_a;
          end
          b_d = node_of(in_node_b);
        end
      end
      ST_AT_DRD: begin
        dep_raddr = DAW'(b_q);
      end
      ST_AT_DWR: begin
        // Depth of the child and its direct parent in level 0.
        dep_we    = 1'b1;
        tbl_we    = 1'b1;
        tbl_waddr = tbl_addr(a_q, '0);
        tbl_wdata = b_q;
        j_d       = JW'(1);
      end
      ST_AT_RD: begin
        // b_q holds the child's ancestor at level j-1; its own level j-1 gives level j.
        tbl_raddr = tbl_addr(b_q, j_q - 1'b1);
      end
      ST_AT_WR: begin
        tbl_we = 1'b1;
        b_d    = tbl_rdata;
        j_d    = j_q + 1'b1;
      end
      ST_Q_DA: begin
        dep_raddr = DAW'(a_q);
      end
      ST_Q_DB: begin
        da_d      = dep_rdata;
        dep_raddr = DAW'(b_q);
      end
      ST_Q_SWAP: begin
        // Put the deeper node in a_q and keep the depth difference.
        j_d = '0;
        if (da_q < dep_rdata) begin
          a_d = b_q;
          b_d = a_q;
          k_d = dep_rdata - da_q;
        end else begin
          k_d = da_q - dep_rdata;
        end
      end
      ST_Q_LIFT: begin
        if (k_q != '0) begin
          if (!(k_q[0] && lift_in_table)) begin
            // A jump beyond the table's reach lands on the sentinel.
            if (k_q[0]) begin
              a_d = '0;
            end
            k_d = k_q >> 1;
            j_d = j_q + 1'b1;
          end
        end
      end
      ST_Q_LWAIT: begin
        a_d = tbl_rdata;
        k_d = k_q >> 1;
        j_d = j_q + 1'b1;
      end
      ST_Q_CHK: begin
        if (a_q != b_q) begin
          j_d = JW'(LEVELS - 1);
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          out_data_d  = a_q;
        end
      end
      ST_Q_UA: begin
        tbl_raddr = tbl_addr(a_q, j_q);
      end
      ST_Q_UB: begin
        ua_d      = tbl_rdata;
        tbl_raddr = tbl_addr(b_q, j_q);
      end
      ST_Q_CMP: begin
        // Step both nodes up only while their ancestors still differ.
        if (ua_q != tbl_rdata) begin
          a_d = ua_q;
          b_d = tbl_rdata;
        end
        if (j_q != '0) begin
          j_d = j_q - 1'b1;
        end else begin
          // After the last level, fetch the direct parent of the final node.
          tbl_raddr = tbl_addr(a_d, '0);
        end
      end
      ST_Q_FIN: begin
        tbl_raddr = tbl_addr(a_q, '0);
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_data_d  = tbl_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    ua_q       <= ua_d;
    da_q       <= da_d;
    k_q        <= k_d;
    j_q        <= j_d;
    out_data_q <= out_data_d;
  end

  lcabl_ram #(
    .WIDTH(NODE_W),
    .DEPTH(TBL_DEPTH)
  ) u_tbl_ram (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i(tbl_wdata),
    .raddr_i(tbl_raddr),
    .rdata_o(tbl_rdata)
  );

  lcabl_ram #(
    .WIDTH(DEPTH_BITS),
    .DEPTH(MAX_NODES)
  ) u_dep_ram (
    .clk_i  (clk_i),
    .we_i   (dep_we),
    .waddr_i(dep_waddr),
    .wdata_i(dep_wdata),
    .raddr_i(dep_raddr),
    .rdata_o(dep_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W - NODE_W){1'b0}}, out_data_q};

  // Neither store is written while the block waits for a beat.
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!tbl_we && !dep_we))
    else $error("store written while idle");

  // Depths are written only by the clearing pass and by an attach.
  a_dep_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dep_we |-> (state_q == ST_CLEAR || state_q == ST_AT_DWR))
    else $error("depth store written outside clear or attach");

  // A result appears only after a query reached one of its answer states.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> ($past(state_q) == ST_Q_CHK || $past(state_q) == ST_Q_FIN))
    else $error("result without a finished query");

  // Table entries read during the joint lift name nodes in range.
  a_table_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_Q_CMP) |-> (32'(ua_q) < MAX_NODES && 32'(tbl_rdata) < MAX_NODES))
    else $error("ancestor entry out of node range");

  // No beat is taken before the clearing pass ends.
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready_o)
    else $error("beat taken during clearing pass");

endmodule

// ===== hdl/lcabl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the ancestor table and the depth store; no package dependency.
module lcabl_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== verif/lca_binary_lifting_tb.sv =====
// Self-checking testbench for lca_binary_lifting: attach and query beats go in, and each
// ancestor beat coming out is compared with a cycle-free model kept in a small class.
// Depends on lcabl_pkg and on the RTL of lca_binary_lifting.
`timescale 1ns / 100ps

module lca_binary_lifting_tb;
  import lcabl_pkg::*;

  localparam int unsigned LEVELS     = LEVELS_DEF;
  localparam int unsigned RAND_BEATS = 330;
  // Length of the directed chain, deep enough to use most lift bits.
  localparam int unsigned CHAIN_LEN  = 300;
  // Watchdog on the whole run, clearing pass included.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Longest query plus some margin, used as the quiet period at the end.
  localparam int unsigned TAIL_CYCLES = 3 * LEVELS + 2 * DEPTH_BITS + 40;

  // Keeps its own ancestor table and depths, and the ancestors still owed by the block.
  class ancestry_board;
    logic [NODE_W-1:0]     lift_tbl [MAX_NODES_DEF][LEVELS];
    logic [DEPTH_BITS-1:0] depth_of [MAX_NODES_DEF];
    logic [NODE_W-1:0]     awaited_ancestors [$];
    int unsigned           mismatch_cnt;

    function new();
      foreach (lift_tbl[n, j]) lift_tbl[n][j] = '0;
      foreach (depth_of[n]) depth_of[n] = '0;
      mismatch_cnt = 0;
    endfunction

    // Every 10-bit node number is below MAX_NODES, so no number maps to the sentinel.
    function logic [NODE_W-1:0] hop(logic [NODE_W-1:0] v, int unsigned j);
      return (j < LEVELS) ? lift_tbl[v][j] : '0;
    endfunction

    task flag_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      mismatch_cnt++;
    endtask

    function int unsigned pending();
      return awaited_ancestors.size();
    endfunction

    function void take_beat(logic [KIND_W-1:0] kind, logic [NODE_W-1:0] a,
                            logic [NODE_W-1:0] b);
      logic [DEPTH_BITS-1:0] d;
      logic [DEPTH_BITS-1:0] k;
      logic [NODE_W-1:0]     x, y, ux, uy, res;
      if (kind == KIND_ATTACH) begin
        // The sentinel can never become a child.
        if (a == '0) return;
        d = depth_of[b];
        depth_of[a] = (d == DEPTH_MAX) ? DEPTH_MAX : d + 1'b1;
        lift_tbl[a][0] = b;
        // Doubling reads the child's own fresh entries, also when it is its own parent.
        for (int unsigned j = 1; j < LEVELS; j++)
          lift_tbl[a][j] = hop(lift_tbl[a][j-1], j - 1);
      end else begin
        x = a;
        y = b;
        if (depth_of[x] < depth_of[y]) begin
          x = b;
          y = a;
        end
        k = depth_of[x] - depth_of[y];
        for (int unsigned j = 0; j < DEPTH_BITS; j++)
          if (k[j]) x = (j < LEVELS) ? hop(x, j) : '0;
        if (x == y) begin
          res = x;
        end else begin
          for (int j = LEVELS - 1; j >= 0; j--) begin
            ux = hop(x, j);
            uy = hop(y, j);
            if (ux != uy) begin
              x = ux;
              y = uy;
            end
          end
          res = hop(x, 0);
        end
        awaited_ancestors = {awaited_ancestors, res};
      end
    endfunction

    task match_ancestor(logic [M_TDATA_W-1:0] beat);
      logic [NODE_W-1:0] want;
      if (awaited_ancestors.size() == 0) begin
        flag_mismatch($sformatf("ancestor %0d arrived with none expected", beat[NODE_W-1:0]));
        return;
      end
      want = awaited_ancestors.pop_front();
      if (beat[NODE_W-1:0] !== want)
        flag_mismatch($sformatf("ancestor %0d, expected %0d", beat[NODE_W-1:0], want));
    endtask
  endclass

  logic                 clk_i   = 1'b0;
  logic                 rst_ni  = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic [KIND_W-1:0]    s_tuser  = KIND_ATTACH;
  logic                 m_tready = 1'b0;
  logic                 s_axis_tready_o;
  logic                 m_axis_tvalid_o;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;

  // When set, neither side idles any more.
  bit                   calm = 1'b0;
  int unsigned          cycle_cnt = 0;
  ancestry_board        board = new();
  // Nodes placed in the forest so far, used to build well-formed attach and query beats.
  logic [NODE_W-1:0]    placed_nodes [$];

  lca_binary_lifting i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("lca_binary_lifting_tb: done, errors");
      $finish;
    end
  end

  // Result side: every accepted ancestor beat goes straight to the board.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) board.match_ancestor(m_axis_tdata_o);
  end

  // Receiver: ready stretches broken by random stalls until the calm part.
  initial begin
    @(posedge clk_i);
    forever begin
      if (calm || $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Sends one beat, maybe after an idle burst, and holds it until the block takes it.
  task automatic send_beat(logic [KIND_W-1:0] kind, logic [NODE_W-1:0] a,
                           logic [NODE_W-1:0] b);
    logic [S_TDATA_W-1:0] beat;
    beat = '0;
    beat[NODE_W-1:0] = a;
    beat[2*NODE_W-1:NODE_W] = b;
    if (!calm && $urandom_range(0, 99) < 25) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= beat;
    s_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.take_beat(kind, a, b);
  endtask

  // Stops sending until the block has returned every ancestor it owes.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  function automatic logic [NODE_W-1:0] known_node();
    if (placed_nodes.size() == 0 || $urandom_range(0, 9) == 0)
      return NODE_W'($urandom_range(0, 1023));
    return placed_nodes[$urandom_range(0, placed_nodes.size() - 1)];
  endfunction

  // Mostly attach beats that extend the forest and queries on placed nodes, some noise.
  task automatic random_beat();
    int unsigned       pick;
    logic [NODE_W-1:0] child, parent;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      send_beat(KIND_W'($urandom_range(0, 1)), NODE_W'($urandom_range(0, 1023)),
                NODE_W'($urandom_range(0, 1023)));
    end else if (pick < 50) begin
      child = NODE_W'($urandom_range(1, 1023));
      if (placed_nodes.size() == 0 || $urandom_range(0, 9) == 0)
        parent = '0;
      else if ($urandom_range(0, 9) < 3)
        parent = placed_nodes[$];
      else
        parent = known_node();
      send_beat(KIND_ATTACH, child, parent);
      placed_nodes = {placed_nodes, child};
    end else begin
      send_beat(KIND_QUERY, known_node(), known_node());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Queries on the cleared stores: sentinel, a lone node, two roots.
    send_beat(KIND_QUERY, 10'd0, 10'd0);
    send_beat(KIND_QUERY, 10'd1023, 10'd1023);
    send_beat(KIND_QUERY, 10'd5, 10'd700);
    // The sentinel as child is ignored.
    send_beat(KIND_ATTACH, 10'd0, 10'd7);
    // A small tree under node 1, with the highest node number as a leaf.
    send_beat(KIND_ATTACH, 10'd1, 10'd0);
    send_beat(KIND_ATTACH, 10'd2, 10'd1);
    send_beat(KIND_ATTACH, 10'd3, 10'd2);
    send_beat(KIND_ATTACH, 10'd4, 10'd2);
    send_beat(KIND_ATTACH, 10'd1023, 10'd4);
    send_beat(KIND_QUERY, 10'd3, 10'd4);
    send_beat(KIND_QUERY, 10'd1023, 10'd3);
    send_beat(KIND_QUERY, 10'd1023, 10'd1);
    send_beat(KIND_QUERY, 10'd1, 10'd1023);
    send_beat(KIND_QUERY, 10'd1023, 10'd0);
    // A leaf below node 1023 and a second root, then a query across the two trees.
    send_beat(KIND_ATTACH, 10'd512, 10'd1023);
    send_beat(KIND_ATTACH, 10'd5, 10'd0);
    send_beat(KIND_QUERY, 10'd512, 10'd5);
    // Re-attach of an inner node: its descendants keep their old tables.
    send_beat(KIND_ATTACH, 10'd4, 10'd5);
    send_beat(KIND_QUERY, 10'd4, 10'd3);
    send_beat(KIND_QUERY, 10'd1023, 10'd512);
    // Alternating bit patterns, with a parent that was never attached.
    send_beat(KIND_ATTACH, 10'd682, 10'd341);
    send_beat(KIND_QUERY, 10'd682, 10'd341);
    // A node made its own parent.
    send_beat(KIND_ATTACH, 10'd6, 10'd6);
    send_beat(KIND_QUERY, 10'd6, 10'd1);

    for (int unsigned i = 0; i < RAND_BEATS; i++) begin
      if (i == 100) begin
        // One long chain, so deep lifts use most of the table levels; closing it into
        // a loop then re-attaches its top under its bottom.
        for (int unsigned n = 1; n <= CHAIN_LEN; n++)
          send_beat(KIND_ATTACH, NODE_W'(n), NODE_W'(n - 1));
        send_beat(KIND_QUERY, NODE_W'(CHAIN_LEN), 10'd1);
        send_beat(KIND_QUERY, NODE_W'(CHAIN_LEN), 10'd2);
        send_beat(KIND_QUERY, 10'd257, 10'd7);
        send_beat(KIND_ATTACH, 10'd1, NODE_W'(CHAIN_LEN));
        send_beat(KIND_ATTACH, 10'd2, 10'd1);
        send_beat(KIND_QUERY, NODE_W'(CHAIN_LEN), 10'd2);
        send_beat(KIND_QUERY, 10'd2, NODE_W'(CHAIN_LEN));
        placed_nodes.delete();
        for (int unsigned n = 1; n < MAX_NODES_DEF; n += 7)
          placed_nodes = {placed_nodes, NODE_W'(n)};
      end
      if (i == 200) drain_results();
      if (i == RAND_BEATS - 100) calm = 1'b1;
      random_beat();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.pending() != 0)
      board.flag_mismatch($sformatf("%0d ancestors never arrived", board.pending()));
    if (board.mismatch_cnt == 0) begin
      $display("lca_binary_lifting_tb: done, clean");
    end else begin
      $display("lca_binary_lifting_tb: done, errors");
    end
    $finish;
  end

endmodule
